FILE: hdl/fcc_pkg.sv
package fcc_pkg;

    localparam int LINK_W  = 32;
    localparam int COUNT_W = 7;
    localparam int CLUS_W  = 9;

    localparam logic [LINK_W-1:0] END_MARK  = 32'h0FFF_FFFF;
    localparam logic [LINK_W-1:0] RESERVED0 = 32'h0FFF_FFF8;
    localparam logic [LINK_W-1:0] RESERVED1 = 32'h0FFF_FFFF;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_WALK  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_TOOLONG  = 2'd2,
        ST_BADINDEX = 2'd3
    } t_status;

    typedef struct packed {
        logic [CLUS_W-1:0] cluster;
        t_status           status;
        logic              last;
    } t_result;

endpackage

FILE: hdl/fat_cluster_chain_manager.sv
// Cluster chain manager over a FAT-style link table held in one single-port-read RAM.
// One request at a time; s_axis_tready is high only while idle. Every table read is
// registered in the RAM, so each step is a read state and then a state that uses the data.
// Allocate counts free entries from entry 0 until it has enough (or reaches the end), then
// rescans and links them, emitting each cluster. Free and walk trace the chain once to check
// it, then follow it again to clear or emit. After reset a clearing pass initializes every
// table entry; no request is taken during it. Results wait in an output register, so a
// stalled master side only pauses the sequencer.
module fat_cluster_chain_manager #(
    parameter int TABLE_ENTRIES = 512,
    parameter int MAX_CHAIN     = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [6:0] alloc_count, [15:7] start_cluster
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [8:0] cluster, [15:9] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);
    import fcc_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int NCNT_W = $clog2(MAX_CHAIN + 1);
    localparam logic [ADDR_W-1:0]  LAST_IDX  = ADDR_W'(TABLE_ENTRIES - 1);
    localparam logic [NCNT_W-1:0]  CHAIN_MAX = NCNT_W'(MAX_CHAIN);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_CHAIN);
    localparam logic [LINK_W-1:0]  ENTRIES   = LINK_W'(TABLE_ENTRIES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ONE,
        S_CNT_RD, S_CNT_CHK, S_LNK_RD, S_LNK_CHK, S_END,
        S_TR_CHK, S_TR_DAT, S_PS_RD, S_PS_DAT
    } t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_idx;
    logic [ADDR_W-1:0]   r_prev;
    logic                r_have_prev;
    logic [COUNT_W-1:0]  r_found;
    logic [COUNT_W-1:0]  r_count;
    logic                r_is_free;
    logic [CLUS_W-1:0]   r_start;
    logic [LINK_W-1:0]   r_cur;
    logic [NCNT_W-1:0]   r_n;
    t_status             r_status;

    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [LINK_W-1:0]   ram_wr_data;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [LINK_W-1:0]   ram_rd_data;

    logic                out_push;
    t_result             out_res;
    t_result             out_q;
    logic                out_free;

    logic                data_zero;
    logic                data_end;
    logic [COUNT_W-1:0]  found_inc;
    logic                cur_bad;
    logic                chain_full;
    logic [COUNT_W-1:0]  in_count;
    logic [1:0]          in_action;

    assign data_zero  = (ram_rd_data == '0);
    assign data_end   = (ram_rd_data == END_MARK);
    assign found_inc  = r_found + 7'd1;
    assign cur_bad    = (r_cur < 32'd2) || (r_cur >= ENTRIES);
    assign chain_full = (r_n == CHAIN_MAX);
    assign in_action  = s_axis_tuser;
    // zero count is the folder case: one cluster
    assign in_count   = (s_axis_tdata[6:0] == '0) ? 7'd1 : s_axis_tdata[6:0];

    assign s_axis_tready = (r_state == S_IDLE);

    fcc_link_ram #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    fcc_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_res   (out_res),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_q)
    );

    assign m_axis_tdata = {7'd0, out_q.cluster};
    assign m_axis_tuser = out_q.status;
    assign m_axis_tlast = out_q.last;

    // table port and result push
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_idx;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_idx;
        out_push    = 1'b0;
        out_res     = '{cluster: '0, status: ST_OK, last: 1'b1};
        unique case (r_state)
            S_CLEAR: begin
                ram_wr_en = 1'b1;
                if (r_idx == ADDR_W'(0)) begin
                    ram_wr_data = RESERVED0;
                end else if (r_idx == ADDR_W'(1)) begin
                    ram_wr_data = RESERVED1;
                end
            end
            S_ONE: begin
                out_push       = out_free;
                out_res.status = r_status;
            end
            S_CNT_RD, S_LNK_RD: begin
                ram_rd_en = 1'b1;
            end
            S_LNK_CHK: begin
                if (data_zero && out_free) begin
                    out_push    = 1'b1;
                    out_res     = '{cluster: CLUS_W'(r_idx), status: ST_OK,
                                    last: (found_inc == r_count)};
                    ram_wr_en   = r_have_prev;
                    ram_wr_addr = r_prev;
                    ram_wr_data = LINK_W'(r_idx);
                end
            end
            S_END: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = END_MARK;
            end
            S_TR_CHK: begin
                ram_rd_en   = !chain_full && !cur_bad;
                ram_rd_addr = r_cur[ADDR_W-1:0];
            end
            S_PS_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_cur[ADDR_W-1:0];
            end
            S_PS_DAT: begin
                ram_wr_addr = r_cur[ADDR_W-1:0];
                if (r_is_free) begin
                    ram_wr_en = !data_end || out_free;
                    out_push  = data_end && out_free;
                end else begin
                    out_push = out_free;
                    out_res  = '{cluster: CLUS_W'(r_cur), status: ST_OK, last: data_end};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_found     <= '0;
            r_count     <= '0;
            r_is_free   <= 1'b0;
            r_start     <= '0;
            r_cur       <= '0;
            r_n         <= '0;
            r_status    <= ST_OK;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_idx       <= '0;
                        r_found     <= '0;
                        r_have_prev <= 1'b0;
                        r_count     <= in_count;
                        r_is_free   <= (in_action == ACT_FREE);
                        r_start     <= s_axis_tdata[15:7];
                        r_cur       <= LINK_W'(s_axis_tdata[15:7]);
                        r_n         <= '0;
                        priority if (in_action == ACT_ALLOC) begin
                            if (in_count > COUNT_MAX) begin
                                r_status <= ST_TOOLONG;
                                r_state  <= S_ONE;
                            end else begin
                                r_state <= S_CNT_RD;
                            end
                        end else if (in_action == ACT_FREE || in_action == ACT_WALK) begin
                            r_state <= S_TR_CHK;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_ONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_CNT_RD: begin
                    r_state <= S_CNT_CHK;
                end
                S_CNT_CHK: begin
                    if (data_zero && found_inc == r_count) begin
                        // enough free entries: rescan and link
                        r_idx       <= '0;
                        r_found     <= '0;
                        r_have_prev <= 1'b0;
                        r_state     <= S_LNK_RD;
                    end else if (r_idx == LAST_IDX) begin
                        r_status <= ST_NOSPACE;
                        r_state  <= S_ONE;
                    end else begin
                        r_found <= r_found + COUNT_W'(data_zero);
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_CNT_RD;
                    end
                end
                S_LNK_RD: begin
                    r_state <= S_LNK_CHK;
                end
                S_LNK_CHK: begin
                    if (!data_zero) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_LNK_RD;
                    end else if (out_free) begin
                        if (found_inc == r_count) begin
                            r_state <= S_END;
                        end else begin
                            r_prev      <= r_idx;
                            r_have_prev <= 1'b1;
                            r_found     <= found_inc;
                            r_idx       <= r_idx + 1'b1;
                            r_state     <= S_LNK_RD;
                        end
                    end
                end
                S_END: begin
                    r_state <= S_IDLE;
                end
                S_TR_CHK: begin
                    // length is checked before the index
                    if (chain_full) begin
                        r_status <= ST_TOOLONG;
                        r_state  <= S_ONE;
                    end else if (cur_bad) begin
                        r_status <= ST_BADINDEX;
                        r_state  <= S_ONE;
                    end else begin
                        r_n     <= r_n + 1'b1;
                        r_state <= S_TR_DAT;
                    end
                end
                S_TR_DAT: begin
                    if (data_end) begin
                        r_cur   <= LINK_W'(r_start);
                        r_state <= S_PS_RD;
                    end else begin
                        r_cur   <= ram_rd_data;
                        r_state <= S_TR_CHK;
                    end
                end
                S_PS_RD: begin
                    r_state <= S_PS_DAT;
                end
                S_PS_DAT: begin
                    if (!data_end && (r_is_free || out_free)) begin
                        r_cur   <= ram_rd_data;
                        r_state <= S_PS_RD;
                    end else if (data_end && out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/fcc_link_ram.sv
module fcc_link_ram #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic [fcc_pkg::LINK_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    output logic [fcc_pkg::LINK_W-1:0] o_rd_data
);
    import fcc_pkg::*;

    logic [LINK_W-1:0] r_mem [DEPTH];
    logic [LINK_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/fcc_out_reg.sv
module fcc_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fcc_pkg::t_result i_res,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output fcc_pkg::t_result o_res
);
    import fcc_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_push) begin
            r_res <= i_res;
        end
    end

endmodule

FILE: tb/fat_cluster_chain_manager_test.sv
`timescale 1ns / 1ps

module fat_cluster_chain_manager_test;

    import fcc_pkg::*;

    localparam int TABLE_ENTRIES = 512;
    localparam int MAX_CHAIN     = 64;
    localparam int RANDOM_ITEMS  = 400;
    localparam logic [1:0] ACT_NONE = 2'd3;   // unused code, block drops it

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // [6:0] alloc_count, [15:7] start_cluster
    logic [1:0]  s_axis_tuser;    // [1:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // [8:0] cluster, [15:9] zero
    logic [1:0]  m_axis_tuser;    // [1:0] status
    logic        m_axis_tlast;

    // shadow of the link table and the results it implies
    logic [LINK_W-1:0] fat_links [TABLE_ENTRIES];
    logic [CLUS_W-1:0] chain_path [MAX_CHAIN];
    logic [CLUS_W-1:0] live_heads [$];
    t_result           pending_results [$];
    int                mismatches;
    logic              quiet;

    fat_cluster_chain_manager #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .MAX_CHAIN    (MAX_CHAIN)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        // keep the log bounded when the block is badly off
        if (mismatches < 100) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    function automatic void queue_result(input logic [CLUS_W-1:0] cluster, input t_status status,
                                         input logic last);
        t_result r;
        r.cluster = cluster;
        r.status  = status;
        r.last    = last;
        pending_results.push_back(r);
    endfunction

    // Follows a chain into chain_path; length is checked before the index.
    function automatic t_status trace_chain(input logic [CLUS_W-1:0] head, output int len);
        logic [LINK_W-1:0] cur;
        t_status           status;
        logic              done;
        cur    = LINK_W'(head);
        status = ST_OK;
        done   = 1'b0;
        len    = 0;
        while (!done) begin
            if (len >= MAX_CHAIN) begin
                status = ST_TOOLONG;
                done   = 1'b1;
            end else if (cur < 2 || cur >= TABLE_ENTRIES) begin
                status = ST_BADINDEX;
                done   = 1'b1;
            end else begin
                chain_path[len] = cur[CLUS_W-1:0];
                len++;
                if (fat_links[cur] == END_MARK) begin
                    done = 1'b1;
                end else begin
                    cur = fat_links[cur];
                end
            end
        end
        return status;
    endfunction

    function automatic void predict_chain_op(input logic [1:0] act, input logic [COUNT_W-1:0] cnt,
                                             input logic [CLUS_W-1:0] start);
        int      need;
        int      len;
        int      i;
        t_status st;
        len = 0;
        if (act == ACT_ALLOC) begin
            need = (cnt == 0) ? 1 : int'(cnt);
            if (need > MAX_CHAIN) begin
                queue_result('0, ST_TOOLONG, 1'b1);
            end else begin
                for (i = 0; i < TABLE_ENTRIES && len < need; i++) begin
                    if (fat_links[i] == '0) begin
                        chain_path[len] = i[CLUS_W-1:0];
                        len++;
                    end
                end
                // all or nothing: the table is untouched when short
                if (len < need) begin
                    queue_result('0, ST_NOSPACE, 1'b1);
                end else begin
                    for (i = 0; i < len; i++) begin
                        if (i + 1 < len) begin
                            fat_links[chain_path[i]] = LINK_W'(chain_path[i + 1]);
                        end else begin
                            fat_links[chain_path[i]] = END_MARK;
                        end
                        queue_result(chain_path[i], ST_OK, i + 1 == len);
                    end
                    live_heads.push_back(chain_path[0]);
                end
            end
        end else if (act == ACT_FREE || act == ACT_WALK) begin
            st = trace_chain(start, len);
            if (st != ST_OK) begin
                queue_result('0, st, 1'b1);
            end else if (act == ACT_FREE) begin
                for (i = 0; i < len; i++) begin
                    fat_links[chain_path[i]] = '0;
                end
                for (i = live_heads.size() - 1; i >= 0; i--) begin
                    if (live_heads[i] == start) begin
                        live_heads.delete(i);
                    end
                end
                queue_result('0, ST_OK, 1'b1);
            end else begin
                for (i = 0; i < len; i++) begin
                    queue_result(chain_path[i], ST_OK, i + 1 == len);
                end
            end
        end
    endfunction

    // Valid stays high from one request to the next unless a gap is taken.
    task automatic issue_request(input logic [1:0] act, input logic [COUNT_W-1:0] cnt,
                                 input logic [CLUS_W-1:0] start);
        while (!quiet && $urandom_range(99) < 16) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {start, cnt};
        s_axis_tuser  <= act;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        predict_chain_op(act, cnt, start);
    endtask

    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 16);
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result cluster %0d status %0d last %0d",
                                          m_axis_tdata[8:0], m_axis_tuser, m_axis_tlast));
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[CLUS_W-1:0] !== want.cluster || m_axis_tuser !== want.status ||
                    m_axis_tlast !== want.last || m_axis_tdata[15:CLUS_W] !== '0) begin
                    report_mismatch($sformatf(
                        "got cluster %0d status %0d last %0d pad %0h, want %0d %0d %0d",
                        m_axis_tdata[CLUS_W-1:0], m_axis_tuser, m_axis_tlast,
                        m_axis_tdata[15:CLUS_W], want.cluster, want.status, want.last));
                end
            end
        end
    end

    task automatic test_bad_index();
        issue_request(ACT_WALK, 7'd0, 9'd0);
        issue_request(ACT_FREE, 7'd0, 9'd1);
        // free entry: its zero link points at reserved entry 0
        issue_request(ACT_WALK, 7'd0, 9'd2);
        wait_results_done();
    endtask

    task automatic test_folder_alloc();
        issue_request(ACT_ALLOC, 7'd0, 9'd0);
        issue_request(ACT_WALK, 7'd0, 9'd2);
        wait_results_done();
    endtask

    task automatic test_oversize_alloc();
        issue_request(ACT_ALLOC, 7'd127, 9'd0);
        issue_request(ACT_ALLOC, 7'(MAX_CHAIN + 1), 9'd0);
        wait_results_done();
    endtask

    // Cut a full-length chain, then relink its tail so it grows past the limit.
    task automatic test_split_chain();
        issue_request(ACT_ALLOC, 7'(MAX_CHAIN), 9'd0);
        issue_request(ACT_WALK, 7'd0, 9'd3);
        issue_request(ACT_FREE, 7'd0, 9'd4);
        issue_request(ACT_WALK, 7'd0, 9'd3);
        issue_request(ACT_ALLOC, 7'(MAX_CHAIN), 9'd0);
        issue_request(ACT_WALK, 7'd0, 9'd3);
        issue_request(ACT_FREE, 7'd0, 9'd3);
        wait_results_done();
    endtask

    task automatic test_unused_action();
        issue_request(ACT_NONE, 7'd127, 9'd511);
        wait_results_done();
    endtask

    task automatic test_fill_table();
        int k;
        for (k = 0; k < 6; k++) begin
            issue_request(ACT_ALLOC, 7'(MAX_CHAIN), 9'd0);
        end
        issue_request(ACT_ALLOC, 7'(MAX_CHAIN), 9'd0);
        issue_request(ACT_ALLOC, 7'd60, 9'd0);
        issue_request(ACT_ALLOC, 7'd0, 9'd0);
        issue_request(ACT_WALK, 7'd0, 9'd511);
        wait_results_done();
    endtask

    task automatic test_random_traffic();
        int                n;
        int                r;
        logic [1:0]        act;
        logic [COUNT_W-1:0] cnt;
        logic [CLUS_W-1:0] start;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= 150 && n < 250);
            cnt   = COUNT_W'($urandom);
            start = CLUS_W'($urandom);
            r     = $urandom_range(99);
            if (r < 40) begin
                act = ACT_ALLOC;
                r   = $urandom_range(99);
                if (r < 70) begin
                    cnt = COUNT_W'($urandom_range(8, 1));
                end else if (r < 80) begin
                    cnt = '0;
                end else if (r < 90) begin
                    cnt = COUNT_W'($urandom_range(MAX_CHAIN, 9));
                end else if (r < 95) begin
                    cnt = COUNT_W'(MAX_CHAIN);
                end else begin
                    cnt = COUNT_W'($urandom_range(127, MAX_CHAIN + 1));
                end
            end else begin
                if (r < 70) begin
                    act = ACT_FREE;
                end else if (r < 95) begin
                    act = ACT_WALK;
                end else begin
                    act = ACT_NONE;
                end
                // mostly known chain heads, some mid-chain or arbitrary starts
                r = $urandom_range(99);
                if (r < 70 && live_heads.size() != 0) begin
                    start = live_heads[$urandom_range(live_heads.size() - 1)];
                end else if (r < 85) begin
                    start = CLUS_W'($urandom_range(TABLE_ENTRIES - 1, 2));
                end
            end
            issue_request(act, cnt, start);
            if (n % 64 == 63) begin
                wait_results_done();
            end
        end
        quiet = 1'b0;
        wait_results_done();
    endtask

    initial begin
        int i;
        mismatches    = 0;
        quiet         = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            fat_links[i] = '0;
        end
        fat_links[0] = RESERVED0;
        fat_links[1] = RESERVED1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_bad_index();
        test_folder_alloc();
        test_oversize_alloc();
        test_split_chain();
        test_unused_action();
        test_fill_table();
        test_random_traffic();

        repeat (64) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/fcc_pkg.sv
hdl/fcc_link_ram.sv
hdl/fcc_out_reg.sv
hdl/fat_cluster_chain_manager.sv
tb/fat_cluster_chain_manager_test.sv
